// ----- rtl/kdlp_pkg.sv -----
// shared types and constants for the key debounce and long-press block
package kdlp_pkg;

    localparam int unsigned FILTER_W = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned KEY_W    = 2;
    localparam int unsigned CODE_W   = 4;

    localparam logic [FILTER_W-1:0] FILTER_TIME_RESET = 7'd5;
    localparam logic [HOLD_W-1:0]   LONG_TIME_RESET   = 16'd100;
    // half of the reset filter time
    localparam logic [COUNT_W-1:0]  COUNT_RESET       = COUNT_W'(FILTER_TIME_RESET / 2);

    // configuration register indexes
    localparam logic CFG_FILTER_TIME = 1'b0;
    localparam logic CFG_LONG_TIME   = 1'b1;

    // event kinds
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // per-key state word as kept in the state memory
    typedef struct packed {
        logic [HOLD_W-1:0]  hold_count;
        logic               key_down;
        logic [COUNT_W-1:0] debounce_count;
    } key_state_t;

    localparam int unsigned STATE_W = $bits(key_state_t);

    localparam key_state_t KEY_STATE_RESET = '{
        hold_count:     '0,
        key_down:       1'b0,
        debounce_count: COUNT_RESET
    };

    // one result item
    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              event_kind;
        logic [KEY_W-1:0]  event_key;
    } key_event_t;

    // outcome of one update step
    typedef struct packed {
        logic       fire;
        key_event_t evt;
        logic       long_reported;
    } update_result_t;

    function automatic logic [CODE_W-1:0] short_code(input logic [KEY_W-1:0] key);
        logic [CODE_W-1:0] k;
        k = CODE_W'(key);
        return CODE_W'((k << 1) + k + 4'd1);
    endfunction

    function automatic logic [CODE_W-1:0] long_code(input logic [KEY_W-1:0] key);
        logic [CODE_W-1:0] k;
        k = CODE_W'(key);
        return CODE_W'((k << 1) + k + 4'd3);
    endfunction

endpackage

// ----- rtl/kdlp_ram.sv -----
// generic single write port ram with registered read
module kdlp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/kdlp_update.sv -----
// next-state and event logic for one scan tick of one key
module kdlp_update (
    input  logic [kdlp_pkg::FILTER_W-1:0] filter_time,
    input  logic [kdlp_pkg::HOLD_W-1:0]   long_time,
    input  logic [kdlp_pkg::KEY_W-1:0]    key,
    input  logic                          pressed,
    input  logic                          long_reported,
    input  kdlp_pkg::key_state_t          cur,
    output kdlp_pkg::key_state_t          nxt,
    output kdlp_pkg::update_result_t      res
);

    logic [kdlp_pkg::COUNT_W-1:0] ft;
    logic [kdlp_pkg::COUNT_W-1:0] full;
    logic [kdlp_pkg::HOLD_W-1:0]  hold_inc;

    assign ft       = kdlp_pkg::COUNT_W'(filter_time);
    assign full     = {filter_time, 1'b0};
    assign hold_inc = cur.hold_count + 16'd1;

    always_comb
    begin
        nxt                   = cur;
        res.fire              = 1'b0;
        res.long_reported     = long_reported;
        res.evt.event_key     = key;
        res.evt.event_kind    = kdlp_pkg::KIND_SHORT;
        res.evt.key_code      = kdlp_pkg::short_code(key);
        if (pressed)
        begin
            if (cur.debounce_count < ft)
            begin
                nxt.debounce_count = ft;
            end
            else if (cur.debounce_count < full)
            begin
                nxt.debounce_count = cur.debounce_count + 8'd1;
            end
            else
            begin
                nxt.key_down = 1'b1;
                if ((long_time != '0) && (cur.hold_count < long_time))
                begin
                    nxt.hold_count = hold_inc;
                    if (hold_inc == long_time)
                    begin
                        res.fire           = 1'b1;
                        res.long_reported  = 1'b1;
                        res.evt.event_kind = kdlp_pkg::KIND_LONG;
                        res.evt.key_code   = kdlp_pkg::long_code(key);
                    end
                end
            end
        end
        else
        begin
            if (cur.debounce_count > ft)
            begin
                nxt.debounce_count = ft;
            end
            else if (cur.debounce_count != '0)
            begin
                nxt.debounce_count = cur.debounce_count - 8'd1;
            end
            else if (cur.key_down)
            begin
                nxt.key_down      = 1'b0;
                res.fire          = !long_reported;
                res.long_reported = 1'b0;
            end
            nxt.hold_count = '0;
        end
    end

endmodule

// ----- rtl/key_debounce_long_press_top.sv -----
// top level of the key debounce and long-press detector
// Debounces up to NUM_KEYS keys that are scanned one sample at a time and reports short and
// long presses. Each input item is one scan tick of one key; the block takes one item per
// clock cycle while the output queue has room. An item is registered in the update stage,
// where its key's state word is read, and its result is written into the output queue, from
// which it is offered on the output. The per-key state memory is read-modify-written; its
// read is registered and covered by a write-back forward path, so ticks of the same key may
// come back to back. Results wait in a three-deep output queue; input ready drops
// only when that queue and the update stage together could run out of room. Key state needs
// no clearing pass after reset: a per-key valid bit makes an unwritten entry read as the reset
// state, so items are taken from the first cycle after reset. Configuration writes are
// always taken and must only be issued while the block is idle. Ticks with a key index of
// NUM_KEYS or above are dropped. The long-press suppression flag is shared by all keys.
module key_debounce_long_press_top #(
    parameter int unsigned NUM_KEYS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // scan tick items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] key_index, [2] key_pressed, [7:3] zero
    // press event items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] event_key, [5:2] key_code, [7:6] zero
    output logic        m_tuser,   // [0] event_kind
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index, // 0 filter_time, 1 long_time
    input  logic [15:0] cfg_data
);

    localparam int unsigned AW         = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int unsigned FIFO_DEPTH = 3;

    // configuration registers
    logic [kdlp_pkg::FILTER_W-1:0] filter_time_reg;
    logic [kdlp_pkg::HOLD_W-1:0]   long_time_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg <= kdlp_pkg::FILTER_TIME_RESET;
            long_time_reg   <= kdlp_pkg::LONG_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kdlp_pkg::CFG_FILTER_TIME: filter_time_reg <= cfg_data[6:0];
                kdlp_pkg::CFG_LONG_TIME:   long_time_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // input unpacking
    logic [kdlp_pkg::KEY_W-1:0] in_key;
    logic                       in_pressed;
    logic                       in_accept;
    logic                       in_range;

    assign in_key     = s_tdata[1:0];
    assign in_pressed = s_tdata[2];
    assign in_accept  = s_tvalid && s_tready;
    assign in_range   = (32'(in_key) < NUM_KEYS);

    // update stage: holds the item whose state word is being read
    logic                       s1_valid_reg;
    logic [kdlp_pkg::KEY_W-1:0] s1_key_reg;
    logic                       s1_pressed_reg;
    logic [AW-1:0]              s1_addr;

    assign s1_addr = AW'(s1_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_key_reg     <= in_key;
            s1_pressed_reg <= in_pressed;
        end
    end

    // per-key state memory
    kdlp_pkg::key_state_t ram_rdata;
    kdlp_pkg::key_state_t cur_state;
    kdlp_pkg::key_state_t nxt_state;

    kdlp_ram #(
        .WIDTH (kdlp_pkg::STATE_W),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr),
        .wdata (nxt_state),
        .re    (in_accept),
        .raddr (AW'(in_key)),
        .rdata (ram_rdata)
    );

    // entries written since reset; others read as the reset state
    logic [NUM_KEYS-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            valid_reg[s1_addr] <= 1'b1;
        end
    end

    // last write-back, forwarded when the next tick hits the same key
    logic                 wb_valid_reg;
    logic [AW-1:0]        wb_addr_reg;
    kdlp_pkg::key_state_t wb_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            wb_addr_reg  <= s1_addr;
            wb_state_reg <= nxt_state;
        end
    end

    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr))
        begin
            cur_state = wb_state_reg;
        end
        else if (valid_reg[s1_addr])
        begin
            cur_state = ram_rdata;
        end
        else
        begin
            cur_state = kdlp_pkg::KEY_STATE_RESET;
        end
    end

    // shared long-press flag
    logic                     long_reported_reg;
    kdlp_pkg::update_result_t upd;

    kdlp_update u_update (
        .filter_time   (filter_time_reg),
        .long_time     (long_time_reg),
        .key           (s1_key_reg),
        .pressed       (s1_pressed_reg),
        .long_reported (long_reported_reg),
        .cur           (cur_state),
        .nxt           (nxt_state),
        .res           (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reported_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            long_reported_reg <= upd.long_reported;
        end
    end

    // output queue
    kdlp_pkg::key_event_t fifo_reg [FIFO_DEPTH];
    logic [1:0]           wr_ptr_reg;
    logic [1:0]           rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 push;
    logic                 pop;
    logic [2:0]           pending;

    assign push    = s1_valid_reg && upd.fire;
    assign pop     = m_tvalid && m_tready;
    assign pending = 3'(count_reg) + 3'(s1_valid_reg);
    // room for the item in flight plus one more
    assign s_tready = (pending < 3'(FIFO_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= upd.evt;
        end
    end

    kdlp_pkg::key_event_t head;

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {2'b00, head.key_code, head.event_key};
    assign m_tuser  = head.event_kind;

    // an in-range item always reaches the update stage next cycle
    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_range) |=> s1_valid_reg)
        else $error("accepted tick did not enter update stage");

    // the queue never overflows: flow control leaves room for the update stage
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < 2'(FIFO_DEPTH)))
        else $error("event pushed into full output queue");

    // a long event leaves the hold count at long_time and sets the shared flag
    a_long_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (upd.evt.event_kind == kdlp_pkg::KIND_LONG))
            |-> (nxt_state.hold_count == long_time_reg))
        else $error("long event with hold count off long_time");

    a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (upd.evt.event_kind == kdlp_pkg::KIND_LONG)) |=> long_reported_reg)
        else $error("long event did not set shared flag");

    // a short event only comes from a down key that has fully released
    a_short_release: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (upd.evt.event_kind == kdlp_pkg::KIND_SHORT))
            |-> (cur_state.key_down && !nxt_state.key_down && !s1_pressed_reg))
        else $error("short event without full release");

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the key debounce and long-press detector

// predicts press events from accepted scan ticks and checks the events that come out
class press_scoreboard;
    logic [6:0]  filter_time;
    logic [15:0] long_time;
    logic [7:0]  debounce_count [4];
    logic        key_down [4];
    logic [15:0] hold_count [4];
    logic        long_reported;
    kdlp_pkg::key_event_t expected_events [$];
    int          errors;

    function new();
        filter_time   = kdlp_pkg::FILTER_TIME_RESET;
        long_time     = kdlp_pkg::LONG_TIME_RESET;
        long_reported = 1'b0;
        errors        = 0;
        for (int k = 0; k < 4; k++)
        begin
            debounce_count[k] = 8'(filter_time >> 1);
            key_down[k]       = 1'b0;
            hold_count[k]     = '0;
        end
    endfunction

    function void write_reg(logic index, logic [15:0] value);
        if (index == kdlp_pkg::CFG_FILTER_TIME)
            filter_time = value[6:0];
        else
            long_time = value;
    endfunction

    function int pending();
        return expected_events.size();
    endfunction

    // one scan tick of one key through the integrating debouncer
    function void note_tick(logic [1:0] key, logic pressed);
        logic [8:0]           filt;
        logic [8:0]           full;
        logic [8:0]           count;
        kdlp_pkg::key_event_t ev;
        filt  = {2'b00, filter_time};
        full  = filt << 1;
        count = {1'b0, debounce_count[key]};
        if (pressed)
        begin
            if (count < filt)
                debounce_count[key] = 8'(filt);
            else if (count < full)
                debounce_count[key] = debounce_count[key] + 8'd1;
            else
            begin
                key_down[key] = 1'b1;
                if (long_time != 0 && hold_count[key] < long_time)
                begin
                    hold_count[key] = hold_count[key] + 16'd1;
                    if (hold_count[key] == long_time)
                    begin
                        long_reported = 1'b1;
                        ev.event_key  = key;
                        ev.event_kind = kdlp_pkg::KIND_LONG;
                        ev.key_code   = 4'(3 * int'(key) + 3);
                        expected_events.push_back(ev);
                    end
                end
            end
        end
        else
        begin
            if (count > filt)
                debounce_count[key] = 8'(filt);
            else if (count != 0)
                debounce_count[key] = debounce_count[key] - 8'd1;
            else if (key_down[key])
            begin
                key_down[key] = 1'b0;
                if (!long_reported)
                begin
                    ev.event_key  = key;
                    ev.event_kind = kdlp_pkg::KIND_SHORT;
                    ev.key_code   = 4'(3 * int'(key) + 1);
                    expected_events.push_back(ev);
                end
                long_reported = 1'b0;
            end
            hold_count[key] = '0;
        end
    endfunction

    function void check_event(logic [1:0] key, logic kind, logic [3:0] code);
        kdlp_pkg::key_event_t ev;
        if (expected_events.size() == 0)
        begin
            errors++;
            if (errors < 30)
                $display("%0t: event with none expected: key %0d kind %0d code %0d",
                         $time, key, kind, code);
            return;
        end
        ev = expected_events.pop_front();
        if (key !== ev.event_key)
        begin
            errors++;
            if (errors < 30)
                $display("%0t: event_key expected %0d actual %0d", $time, ev.event_key, key);
        end
        if (kind !== ev.event_kind)
        begin
            errors++;
            if (errors < 30)
                $display("%0t: event_kind expected %0d actual %0d", $time, ev.event_kind, kind);
        end
        if (code !== ev.key_code)
        begin
            errors++;
            if (errors < 30)
                $display("%0t: key_code expected %0d actual %0d", $time, ev.key_code, code);
        end
    endfunction
endclass

module tb_top;

    // cycles with no item, result or register write taken before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // length of the forced receiver hold-off that backs the block up
    localparam int HOLD_OFF_CYCLES = 300;
    // cycles allowed after the last result for ticks still in the pipeline
    localparam int PIPE_SETTLE = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = kdlp_pkg::CFG_FILTER_TIME;
    logic [15:0] cfg_data = '0;

    press_scoreboard events_sb;

    // traffic shaping knobs; all but squeeze_hold and quiet_cycles change only between phases
    bit          send_idle = 1'b0;
    logic        recv_stall = 1'b0;
    bit          squeeze_go = 1'b0;
    logic        squeeze_hold = 1'b0;
    int          quiet_cycles = 0;
    // percent of cycles that the sender idles or the receiver stalls
    int          gap_pct = 61;

    // last level driven per key, so bursts alternate press and release
    logic        key_level [4] = '{1'b0, 1'b0, 1'b0, 1'b0};

    key_debounce_long_press_top #(
        .NUM_KEYS (4)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: check what was taken at this edge, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            events_sb.check_event(m_tdata[1:0], m_tuser, m_tdata[5:2]);
        if (squeeze_hold)
            m_tready <= 1'b0;
        else if (recv_stall)
            m_tready <= ($urandom_range(0, 99) >= gap_pct);
        else
            m_tready <= 1'b1;
    end

    // one long receiver hold-off while the sender keeps offering ticks, so the
    // output queue fills and the block has to drop s_tready
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        squeeze_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_hold <= 1'b0;
    end

    // hang detector: any handshake on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one scan tick, optionally after some idle cycles, and wait until it is taken
    task automatic send_tick(input logic [1:0] key, input logic pressed);
        if (send_idle && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, pressed, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        events_sb.note_tick(key, pressed);
    endtask

    // write both registers back to back; valid stays high between the two writes
    task automatic set_config(input logic [6:0] filt, input logic [15:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= kdlp_pkg::CFG_FILTER_TIME;
        cfg_data  <= {9'd0, filt};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        events_sb.write_reg(kdlp_pkg::CFG_FILTER_TIME, {9'd0, filt});
        cfg_index <= kdlp_pkg::CFG_LONG_TIME;
        cfg_data  <= hold;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        events_sb.write_reg(kdlp_pkg::CFG_LONG_TIME, hold);
        cfg_valid <= 1'b0;
    endtask

    // stop offering ticks, wait for every predicted event, then let the pipeline empty
    // since the last ticks may cause no event at all
    task automatic drain();
        s_tvalid <= 1'b0;
        while (events_sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // one phase of random bursts: mostly a key held long enough to settle in the
    // opposite state (and often reach long press), the rest short glitches
    task automatic run_phase(input logic [6:0] filt, input logic [15:0] hold,
                             input bit idle, input logic stall, input int n_ticks,
                             input bit squeeze);
        int         sent;
        int         len;
        int         hold_cap;
        logic [1:0] key;
        logic       lvl;
        drain();
        set_config(filt, hold);
        send_idle  = idle;
        gap_pct    = (idle && stall) ? 26 : 61;
        recv_stall <= stall;
        if (squeeze)
            squeeze_go = 1'b1;
        hold_cap = (hold > 30) ? 30 : int'(hold);
        sent = 0;
        while (sent < n_ticks)
        begin
            key = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 80)
            begin
                lvl = !key_level[key];
                if (lvl)
                    len = 2 * int'(filt) + 2 + $urandom_range(0, hold_cap + 2);
                else
                    len = int'(filt) + 2 + $urandom_range(0, 3);
            end
            else
            begin
                lvl = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 3);
            end
            key_level[key] = lvl;
            repeat (len) send_tick(key, lvl);
            sent += len;
        end
    endtask

    initial
    begin
        events_sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: filter 1 and long time 2, counters keep their reset values
        set_config(7'd1, 16'd2);
        // key 0 reaches long press, its release is then suppressed
        repeat (4) send_tick(2'd0, 1'b1);
        repeat (3) send_tick(2'd0, 1'b0);
        // key 1 also reaches long press, so its release is suppressed
        repeat (2) send_tick(2'd1, 1'b1);
        repeat (3) send_tick(2'd1, 1'b0);
        // key 3 long press, then key 2 release is suppressed by the shared flag
        repeat (2) send_tick(2'd3, 1'b1);
        send_tick(2'd2, 1'b1);
        send_tick(2'd3, 1'b1);
        repeat (3) send_tick(2'd2, 1'b0);
        // flag now clear, so key 3 release gives a short press
        repeat (3) send_tick(2'd3, 1'b0);

        // random phases over several settings and traffic patterns
        run_phase(7'd3,   16'd6,     1'b0, 1'b0, 260, 1'b0);
        run_phase(7'd0,   16'd1,     1'b1, 1'b0, 220, 1'b0);  // zero filter
        run_phase(7'd2,   16'd0,     1'b0, 1'b1, 220, 1'b0);  // long press off
        run_phase(7'd127, 16'd65535, 1'b1, 1'b1, 200, 1'b0);  // both maxima
        run_phase(7'd1,   16'd4,     1'b0, 1'b0, 220, 1'b1);  // forced backpressure
        run_phase(7'd4,   16'd10,    1'b1, 1'b0, 220, 1'b0);
        run_phase(7'd2,   16'd3,     1'b0, 1'b1, 200, 1'b0);
        run_phase(7'd6,   16'd20,    1'b1, 1'b1, 200, 1'b0);
        drain();

        // anything still queued in the block is an event that was never predicted
        if (m_tvalid)
        begin
            events_sb.errors++;
            $display("%0t: event expected none actual key %0d kind %0d code %0d",
                     $time, m_tdata[1:0], m_tuser, m_tdata[5:2]);
        end

        if (events_sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
